@@ design/tdli_pkg.sv @@
// ---------------------------------------------------------------------------
// Timestamped delay line interpolator package
// Shared payload types and controller/datapath command and status structs.
// ---------------------------------------------------------------------------
package tdli_pkg;

	typedef struct packed {
		logic [31:0]        now_time;
		logic signed [31:0] now_value;
		logic [31:0]        wanted_time;
		logic               first_query;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               store_full;
	} out_item_t;

	// Read address source
	localparam logic [2:0] RA_NEWEST = 3'd0;
	localparam logic [2:0] RA_PTR    = 3'd1;
	localparam logic [2:0] RA_PTR_P1 = 3'd2;
	localparam logic [2:0] RA_ZERO   = 3'd3;

	typedef struct packed {
		logic       load_item;   // capture input beat
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       cap_a;       // capture read data into slot A (t1/v1)
		logic       cap_b;       // capture read data into slot B (t2/v2)
		logic       cap_oldest;  // capture slot 0 value
		logic       cap_newest;  // capture newest value
		logic       ptr_newest;  // pointer := newest
		logic       ptr_start;   // pointer := search start
		logic       ptr_dec;
		logic       ptr_inc;
		logic       wr_en;       // write now sample at pointer
		logic       wr_val;      // overwrite only the value at pointer
		logic       wr_fill;     // write at fill_count (append)
		logic       upd_trunc;   // newest := ptr, fill := ptr+1
		logic       hint_clear;
		logic       hint_set;
		logic       flag_full;
		logic       set_pair_now; // B := (now_time, now_value)
		logic       set_pair_wide; // A := (0, oldest), B := (now, newest)
		logic       res_now;
		logic       res_a;
		logic       res_v1;
		logic       res_newest;
		logic       div_start;
		logic       emit;
	} ctl_t;

	typedef struct packed {
		logic fq;
		logic empty;
		logic full;
		logic near_tw;     // near(now_time, wanted)
		logic rd_near_t;   // near(rd_time, now_time)
		logic rd_lt_t;     // rd_time < now_time
		logic rd_gt_t;     // rd_time > now_time
		logic ptr_zero;
		logic ptr_p1_lt_fill;
		logic ptr_is_newest;
		logic w_lt_rd;     // wanted < rd_time
		logic in_pair;     // t1 <= w <= t2
		logic t1_ge_now;
		logic lerp_v1;     // lerp answers v1 directly
		logic lerp_v2;     // lerp answers v2 directly
		logic div_done;
	} sts_t;

endpackage

@@ design/timestamped_delay_line_interpolator.sv @@
// ---------------------------------------------------------------------------
// Timestamped delay line interpolator
// Variable transport delay over a history of timestamped Q16.16 samples.
// ---------------------------------------------------------------------------
// A query beat is taken when start is high and busy is low. The block stores
// the current sample on a first query, then looks up the wanted time and
// presents one result on result for a single cycle, marked by done.
// A store update with an earlier time walks back from the newest slot to the
// slot it overwrites. A look-up walks back from the search start to the last
// slot at or before the wanted time, and an interpolation that needs the
// divide waits on the 64-step restoring divider. The history store has one
// registered read port, so the slots are read one after another.
// Only one query is in flight; busy stays high until done. The user writes
// time_tolerance through cfg_we/cfg_data only while the block is idle;
// the block does not enforce this. Reset empties the history, clears the
// search hint and the tolerance; the store contents themselves are never
// cleared, as no slot is read before it is written. The receiver cannot
// stall: each result must be taken in the cycle done is high.
// ---------------------------------------------------------------------------
module timestamped_delay_line_interpolator #(
	parameter int DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tdli_pkg::in_item_t  query,
	output logic                busy,
	output logic                done,
	output tdli_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	tdli_pkg::ctl_t ctl;
	tdli_pkg::sts_t sts;
	logic [15:0]    tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     tol_q <= '0;
		else if (cfg_we) tol_q <= cfg_data;
	end

	tdli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	tdli_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (query),
		.tol    (tol_q),
		.ctl    (ctl),
		.sts    (sts),
		.res    (result)
	);

endmodule

@@ design/tdli_divider.sv @@
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tdli_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted  = {rem_q[31:0], quo_q[63]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

endmodule

@@ design/tdli_datapath.sv @@
// ---------------------------------------------------------------------------
// Delay line datapath
// Sample store, pointers, operand registers and interpolation arithmetic.
// ---------------------------------------------------------------------------
module tdli_datapath #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tdli_pkg::in_item_t  item,
	input  logic [15:0]         tol,
	input  tdli_pkg::ctl_t      ctl,
	output tdli_pkg::sts_t      sts,
	output tdli_pkg::out_item_t res
);

	logic [31:0] times_mem  [DEPTH];
	logic [31:0] values_mem [DEPTH];

	tdli_pkg::in_item_t it_q;
	logic [AW:0]   fill_q;
	logic [AW-1:0] newest_q;
	logic [AW:0]   hint_q;
	logic [AW-1:0] ptr_q;
	logic          full_q;
	logic [31:0]   rd_time_q, rd_value_q;
	logic [31:0]   t1_q, t2_q;
	logic signed [31:0] v1_q, v2_q;
	logic signed [31:0] oldest_v_q, newest_v_q;
	logic signed [31:0] res_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] start_ptr;
	logic          diff_neg_q;
	logic [31:0]   mag_q, off_q, span_q;
	logic [63:0]   prod_q;
	logic          div_go_q;
	logic [63:0]   quo;
	logic          div_done;

	function automatic logic near_f(input logic [31:0] a, input logic [31:0] b,
			input logic [15:0] t);
		logic [31:0] d;
		d = (a >= b) ? a - b : b - a;
		return d <= {16'd0, t};
	endfunction

	always_comb begin
		start_ptr = (hint_q == '0 || hint_q > {1'b0, newest_q}) ? newest_q : hint_q[AW-1:0];
		case (ctl.rd_sel)
			tdli_pkg::RA_NEWEST: rd_addr = newest_q;
			tdli_pkg::RA_PTR:    rd_addr = ptr_q;
			tdli_pkg::RA_PTR_P1: rd_addr = ptr_q + AW'(1);
			default:             rd_addr = '0;
		endcase
	end

	// Store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			times_mem[ptr_q]  <= it_q.now_time;
			values_mem[ptr_q] <= it_q.now_value;
		end else if (ctl.wr_val) begin
			values_mem[ptr_q] <= it_q.now_value;
		end else if (ctl.wr_fill) begin
			times_mem[fill_q[AW-1:0]]  <= it_q.now_time;
			values_mem[fill_q[AW-1:0]] <= it_q.now_value;
		end
		if (ctl.rd_en) begin
			rd_time_q  <= times_mem[rd_addr];
			rd_value_q <= values_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			newest_q <= '0;
			hint_q   <= '0;
			ptr_q    <= '0;
			full_q   <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= ctl.div_start;
			if (ctl.load_item)  full_q <= 1'b0;
			if (ctl.flag_full)  full_q <= 1'b1;
			if (ctl.hint_clear) hint_q <= '0;
			if (ctl.hint_set)   hint_q <= {1'b0, ptr_q};
			if (ctl.ptr_newest) ptr_q <= newest_q;
			else if (ctl.ptr_start) ptr_q <= start_ptr;
			else if (ctl.ptr_dec) ptr_q <= ptr_q - AW'(1);
			else if (ctl.ptr_inc) ptr_q <= ptr_q + AW'(1);
			if (ctl.wr_fill) begin
				newest_q <= fill_q[AW-1:0];
				fill_q   <= fill_q + (AW+1)'(1);
			end
			if (ctl.upd_trunc) begin
				newest_q <= ptr_q;
				fill_q   <= {1'b0, ptr_q} + (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) it_q <= item;
		if (ctl.cap_a) begin
			t1_q <= rd_time_q;
			v1_q <= rd_value_q;
		end
		if (ctl.cap_b) begin
			t2_q <= rd_time_q;
			v2_q <= rd_value_q;
		end
		if (ctl.set_pair_now) begin
			t2_q <= it_q.now_time;
			v2_q <= it_q.now_value;
		end
		if (ctl.set_pair_wide) begin
			t1_q <= '0;
			v1_q <= oldest_v_q;
			t2_q <= it_q.now_time;
			v2_q <= newest_v_q;
		end
		if (ctl.cap_oldest) oldest_v_q <= rd_value_q;
		if (ctl.cap_newest) newest_v_q <= rd_value_q;
		// Operands for the division, prepared the cycle the controller starts it.
		if (ctl.div_start) begin
			diff_neg_q <= v2_q < v1_q;
			mag_q      <= (v2_q < v1_q) ? 32'(v1_q - v2_q) : 32'(v2_q - v1_q);
			off_q      <= it_q.wanted_time - t1_q;
			span_q     <= t2_q - t1_q;
		end
		if (div_go_q) prod_q <= 64'(mag_q) * 64'(off_q) + 64'(span_q >> 1);
		if (ctl.res_now)    res_q <= it_q.now_value;
		if (ctl.res_a)      res_q <= rd_value_q;
		if (ctl.res_v1)     res_q <= v1_q;
		if (ctl.res_newest) res_q <= newest_v_q;
		if (ctl.emit && div_done)
			res_q <= diff_neg_q ? v1_q - 32'(quo) : v1_q + 32'(quo);
	end

	logic div_go2_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_go2_q <= 1'b0;
		else         div_go2_q <= div_go_q;
	end

	tdli_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go2_q),
		.dividend (prod_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		sts.fq             = it_q.first_query;
		sts.empty          = fill_q == '0;
		sts.full           = fill_q >= (AW+1)'(DEPTH);
		sts.near_tw        = near_f(it_q.now_time, it_q.wanted_time, tol);
		sts.rd_near_t      = near_f(rd_time_q, it_q.now_time, tol);
		sts.rd_lt_t        = rd_time_q < it_q.now_time;
		sts.rd_gt_t        = rd_time_q > it_q.now_time;
		sts.ptr_zero       = ptr_q == '0;
		sts.ptr_p1_lt_fill = ({1'b0, ptr_q} + (AW+1)'(1)) < fill_q;
		sts.ptr_is_newest  = ptr_q == newest_q;
		sts.w_lt_rd        = it_q.wanted_time < rd_time_q;
		sts.in_pair        = t1_q <= it_q.wanted_time && t2_q >= it_q.wanted_time;
		sts.t1_ge_now      = t1_q >= it_q.now_time;
		sts.lerp_v1        = it_q.wanted_time < t1_q || near_f(t1_q, t2_q, tol)
			|| near_f(t1_q, it_q.wanted_time, tol) || t2_q == t1_q;
		sts.lerp_v2        = it_q.wanted_time > t2_q;
		sts.div_done       = div_done;
		res.result_value   = res_q;
		res.store_full     = full_q;
	end

endmodule

@@ design/tdli_ctrl.sv @@
// ---------------------------------------------------------------------------
// Delay line controller
// Sequences store update, backward searches and interpolation per query.
// ---------------------------------------------------------------------------
module tdli_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tdli_pkg::sts_t sts,
	output tdli_pkg::ctl_t ctl,
	output logic           busy,
	output logic           done
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_UPD_RD  = 5'd1;
	localparam logic [4:0] S_UPD_CHK = 5'd2;
	localparam logic [4:0] S_FS_RD   = 5'd3;
	localparam logic [4:0] S_FS_CHK  = 5'd4;
	localparam logic [4:0] S_FS_NXT  = 5'd5;
	localparam logic [4:0] S_FS_NCHK = 5'd6;
	localparam logic [4:0] S_Q       = 5'd7;
	localparam logic [4:0] S_Q_OLD   = 5'd8;
	localparam logic [4:0] S_Q_NEW   = 5'd9;
	localparam logic [4:0] S_IS_RD   = 5'd10;
	localparam logic [4:0] S_IS_CHK  = 5'd11;
	localparam logic [4:0] S_P_RD    = 5'd12;
	localparam logic [4:0] S_P_CAP   = 5'd13;
	localparam logic [4:0] S_DECIDE  = 5'd14;
	localparam logic [4:0] S_LERP    = 5'd15;
	localparam logic [4:0] S_DIV     = 5'd16;
	localparam logic [4:0] S_OUT     = 5'd17;
	localparam logic [4:0] S_Q_W     = 5'd18;
	localparam logic [4:0] S_Q_OCAP  = 5'd19;

	logic [4:0] state_q, state_d;
	logic       wide_q, wide_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		wide_d  = wide_q;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load_item = 1'b1;
					state_d       = S_UPD_RD;
				end
			end
			S_UPD_RD: begin
				if (sts.fq) begin
					ctl.hint_clear = 1'b1;
					ctl.rd_en      = 1'b1;
					ctl.rd_sel     = tdli_pkg::RA_NEWEST;
					ctl.ptr_newest = 1'b1;
					state_d        = S_UPD_CHK;
				end else begin
					state_d = S_Q;
				end
			end
			S_UPD_CHK: begin
				if (!sts.empty && sts.rd_near_t) begin
					// The newest slot keeps its own time; only the value changes.
					ctl.wr_val = 1'b1;
					state_d    = S_Q;
				end else if (sts.empty || sts.rd_lt_t) begin
					if (sts.full) ctl.flag_full = 1'b1;
					else          ctl.wr_fill   = 1'b1;
					state_d = S_Q;
				end else begin
					// The read of the newest slot is already held: examine it.
					state_d = S_FS_CHK;
				end
			end
			S_FS_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = tdli_pkg::RA_PTR;
				state_d    = S_FS_CHK;
			end
			S_FS_CHK: begin
				if (sts.rd_near_t) begin
					ctl.wr_en = 1'b1; ctl.upd_trunc = 1'b1; state_d = S_Q;
				end else if (sts.rd_lt_t) begin
					if (sts.ptr_p1_lt_fill) begin
						ctl.rd_en = 1'b1; ctl.rd_sel = tdli_pkg::RA_PTR_P1;
						state_d = S_FS_NXT;
					end else begin
						ctl.wr_en = 1'b1; ctl.upd_trunc = 1'b1; state_d = S_Q;
					end
				end else if (sts.ptr_zero) begin
					ctl.wr_en = 1'b1; ctl.upd_trunc = 1'b1; state_d = S_Q;
				end else begin
					ctl.ptr_dec = 1'b1; state_d = S_FS_RD;
				end
			end
			S_FS_NXT: state_d = S_FS_NCHK;
			S_FS_NCHK: begin
				if (sts.rd_gt_t || sts.rd_near_t) ctl.ptr_inc = 1'b1;
				state_d = S_Q_W;
			end
			S_Q_W: begin
				ctl.wr_en = 1'b1; ctl.upd_trunc = 1'b1; state_d = S_Q;
			end
			S_Q: begin
				if (sts.near_tw || sts.empty) begin
					ctl.res_now = 1'b1; state_d = S_OUT;
				end else begin
					ctl.rd_en = 1'b1; ctl.rd_sel = tdli_pkg::RA_ZERO;
					state_d = S_Q_OCAP;
				end
			end
			S_Q_OCAP: begin
				ctl.cap_oldest = 1'b1;
				if (sts.w_lt_rd) begin
					ctl.res_a = 1'b1; state_d = S_OUT;
				end else begin
					ctl.rd_en = 1'b1; ctl.rd_sel = tdli_pkg::RA_NEWEST;
					state_d = S_Q_OLD;
				end
			end
			S_Q_OLD: begin
				ctl.ptr_start = 1'b1; state_d = S_Q_NEW;
			end
			S_Q_NEW: begin
				ctl.cap_newest = 1'b1; state_d = S_IS_RD;
			end
			S_IS_RD: begin
				ctl.rd_en = 1'b1; ctl.rd_sel = tdli_pkg::RA_PTR; state_d = S_IS_CHK;
			end
			S_IS_CHK: begin
				if (sts.ptr_zero || !sts.w_lt_rd) begin
					ctl.hint_set = 1'b1; ctl.cap_a = 1'b1;
					if (sts.ptr_is_newest) begin
						ctl.set_pair_now = 1'b1; state_d = S_DECIDE;
					end else begin
						ctl.rd_en = 1'b1; ctl.rd_sel = tdli_pkg::RA_PTR_P1;
						state_d = S_P_RD;
					end
				end else begin
					ctl.ptr_dec = 1'b1; state_d = S_IS_RD;
				end
			end
			S_P_RD: state_d = S_P_CAP;
			S_P_CAP: begin
				ctl.cap_b = 1'b1; state_d = S_DECIDE;
			end
			S_DECIDE: begin
				wide_d = 1'b0;
				if (sts.in_pair) state_d = S_LERP;
				else if (sts.t1_ge_now) begin
					ctl.res_newest = 1'b1; state_d = S_OUT;
				end else begin
					ctl.set_pair_wide = 1'b1; wide_d = 1'b1; state_d = S_LERP;
				end
			end
			S_LERP: begin
				if (sts.lerp_v2) begin
					ctl.cap_b = 1'b0; state_d = S_OUT;
					ctl.res_newest = wide_q;
					ctl.res_now = !wide_q && sts.ptr_is_newest;
					ctl.res_a = 1'b0;
					if (!wide_q && !sts.ptr_is_newest) begin
						ctl.res_a = 1'b1; // read data still holds slot s+1
					end
				end else if (sts.lerp_v1) begin
					ctl.res_v1 = 1'b1; state_d = S_OUT;
				end else begin
					ctl.div_start = 1'b1; state_d = S_DIV;
				end
			end
			S_DIV: begin
				ctl.emit = 1'b1;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				done = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wide_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wide_q  <= wide_d;
		end
	end

endmodule

@@ design/tdli_checker.sv @@
// ---------------------------------------------------------------------------
// Delay line port checker
// Watches the top level's handshake over time.
// ---------------------------------------------------------------------------
module tdli_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");

endmodule

bind timestamped_delay_line_interpolator tdli_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Delay line interpolator testbench
// Drives query beats in random bursts and gaps, predicts each result from an
// internal copy of the sample history and compares it with the block output.
// The tolerance register is swept across several phases, extremes included.
// ---------------------------------------------------------------------------
module tb;

	localparam int HIST_DEPTH = 1024;
	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_PHASE = 112;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	tdli_pkg::in_item_t  query = '0;
	logic                busy;
	logic                done;
	tdli_pkg::out_item_t result;
	logic                cfg_we = 1'b0;
	logic [15:0]         cfg_data = '0;

	timestamped_delay_line_interpolator #(.DEPTH(HIST_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .query(query), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predicted copy of the history store and its bookkeeping.
	logic [31:0]        hist_time [HIST_DEPTH];
	logic signed [31:0] hist_val  [HIST_DEPTH];
	int                 hist_fill;
	int                 hist_newest;
	int                 hist_hint;
	logic [15:0]        tol;

	tdli_pkg::in_item_t  pending_queries[$];
	tdli_pkg::out_item_t awaited_results[$];

	int errors;
	int n_sent;
	int n_results;
	int n_full;
	int n_phases;
	int idle_cycles;
	int burst_left;
	int gap_left;

	// Generator cursor: latest stored time and rough start of the history.
	logic [31:0] gen_t;
	logic [31:0] base_t;

	function automatic bit within_tol(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = (a >= b) ? a - b : b - a;
		return d <= {16'd0, tol};
	endfunction

	function automatic logic signed [31:0] lerp_val(logic [31:0] t1, logic signed [31:0] v1,
		logic [31:0] t2, logic signed [31:0] v2, logic [31:0] w);
		longint      diff;
		logic [31:0] dspan;
		logic [31:0] doff;
		logic [63:0] mag;
		logic [63:0] span;
		logic [63:0] q;
		if (w < t1) return v1;
		if (w > t2) return v2;
		if (within_tol(t1, t2) || within_tol(t1, w)) return v1;
		dspan = t2 - t1;
		doff = w - t1;
		span = {32'd0, dspan};
		if (span == 0) return v1;
		diff = longint'(v2) - longint'(v1);
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		q = (mag * {32'd0, doff} + span / 2) / span;
		if (diff < 0) return 32'(longint'(v1) - longint'(q));
		return 32'(longint'(v1) + longint'(q));
	endfunction

	// Slot that an earlier time overwrites: walks back from the newest sample.
	function automatic int rollback_slot(logic [31:0] t);
		int s;
		s = hist_newest;
		forever begin
			if (within_tol(hist_time[s], t)) return s;
			if (hist_time[s] < t) begin
				if (s + 1 < hist_fill && (hist_time[s+1] > t || within_tol(t, hist_time[s+1])))
					return s + 1;
				return s;
			end
			if (s == 0) return 0;
			s--;
		end
	endfunction

	// Updates the history for one query beat and returns the delayed value.
	function automatic tdli_pkg::out_item_t apply_query(tdli_pkg::in_item_t q);
		tdli_pkg::out_item_t r;
		int          s;
		int          from;
		logic [31:0] t;
		logic [31:0] w;
		logic [31:0] t1;
		logic [31:0] t2;
		logic signed [31:0] v;
		logic signed [31:0] v1;
		logic signed [31:0] v2;
		t = q.now_time;
		v = q.now_value;
		w = q.wanted_time;
		r.store_full = 1'b0;
		if (q.first_query) begin
			hist_hint = 0;
			if (hist_fill > 0 && within_tol(hist_time[hist_newest], t)) begin
				hist_val[hist_newest] = v;
			end else if (hist_fill == 0 || hist_time[hist_newest] < t) begin
				if (hist_fill >= HIST_DEPTH) begin
					r.store_full = 1'b1;
				end else begin
					hist_time[hist_fill] = t;
					hist_val[hist_fill] = v;
					hist_newest = hist_fill;
					hist_fill++;
				end
			end else begin
				s = rollback_slot(t);
				hist_time[s] = t;
				hist_val[s] = v;
				hist_newest = s;
				hist_fill = s + 1;
			end
		end
		if (within_tol(t, w) || hist_fill == 0) begin
			r.result_value = v;
		end else if (w < hist_time[0]) begin
			r.result_value = hist_val[0];
		end else begin
			from = (hist_hint == 0 || hist_hint > hist_newest) ? hist_newest : hist_hint;
			for (s = from; s >= 1; s--)
				if (w >= hist_time[s]) break;
			if (s < 0) s = 0;
			t1 = hist_time[s];
			v1 = hist_val[s];
			hist_hint = s;
			if (s == hist_newest) begin
				t2 = t;
				v2 = v;
			end else begin
				t2 = hist_time[s+1];
				v2 = hist_val[s+1];
			end
			if (t1 <= w && t2 >= w)
				r.result_value = lerp_val(t1, v1, t2, v2, w);
			else if (t1 >= t)
				r.result_value = hist_val[hist_newest];
			else
				r.result_value = lerp_val(32'd0, hist_val[0], t, hist_val[hist_newest], w);
		end
		return r;
	endfunction

	// Driver: bursts of beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			query <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(apply_query(query));
				n_sent++;
			end
			if (start && busy) begin
				// beat not yet taken, hold it
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_queries.size() > 0) begin
				start <= 1'b1;
				query <= pending_queries.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (awaited_results.size() == 0) begin
				$error("result beat with no query outstanding");
				errors++;
			end else begin
				tdli_pkg::out_item_t e;
				e = awaited_results.pop_front();
				if (result.store_full) n_full++;
				if (result.result_value !== e.result_value) begin
					$error("result_value expected %h actual %h", e.result_value,
						result.result_value);
					errors++;
				end
				if (result.store_full !== e.store_full) begin
					$error("store_full expected %b actual %b", e.store_full, result.store_full);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which no beat moves.
	always @(posedge clk) begin
		if (arst_n && !((start && !busy) || done) && !cfg_we) idle_cycles++;
		else idle_cycles = 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic tdli_pkg::in_item_t mk(logic [31:0] t, logic [31:0] v, logic [31:0] w,
		bit fq);
		tdli_pkg::in_item_t q;
		q.now_time = t;
		q.now_value = v;
		q.wanted_time = w;
		q.first_query = fq;
		return q;
	endfunction

	// Sampled away from the rising edge so the driver's updates have settled.
	task automatic drain();
		while (pending_queries.size() != 0 || start || busy || awaited_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_tol(logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol = val;
		n_phases++;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// One call: a first query followed by a few repeat queries.
	task automatic queue_call();
		logic [31:0] t;
		logic [31:0] v;
		logic [31:0] w;
		logic [31:0] span;
		int          r;
		int          k;
		span = gen_t - base_t;
		r = $urandom_range(0, 99);
		if (r < 60) t = gen_t + $urandom_range(1, 32'h0004_0000);
		else if (r < 70) t = gen_t + $urandom_range(0, tol);
		else if (r < 85) t = gen_t - $urandom_range(0, span);
		else if (r < 93) t = $urandom;
		else t = (base_t > 0) ? base_t - $urandom_range(1, base_t) : 32'd0;
		if (t < base_t) base_t = t;
		gen_t = t;
		v = rand_value();
		for (k = 0; k <= $urandom_range(0, 3); k++) begin
			span = (t >= base_t) ? t - base_t : 32'd0;
			r = $urandom_range(0, 99);
			if (r < 15) w = t;
			else if (r < 70) w = t - $urandom_range(0, span);
			else if (r < 80) w = t + $urandom_range(1, 32'h0001_0000);
			else if (r < 90) w = (base_t > 0) ? base_t - $urandom_range(1, base_t) : 32'd0;
			else w = $urandom;
			if (k > 0 && $urandom_range(0, 4) == 0)
				pending_queries.push_back(mk($urandom, rand_value(), w, 1'b0));
			else
				pending_queries.push_back(mk(t, v, w, k == 0));
		end
	endtask

	initial begin
		logic [15:0] phase_tol [5];
		int i;
		errors = 0;
		n_sent = 0;
		n_results = 0;
		n_full = 0;
		n_phases = 0;
		idle_cycles = 0;
		hist_fill = 0;
		hist_newest = 0;
		hist_hint = 0;
		tol = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty history, exact and outside-window look-ups, extremes.
		pending_queries.push_back(mk(32'h0001_0000, 32'h1234_5678, 32'h0000_8000, 1'b0));
		pending_queries.push_back(mk(32'h0001_0000, 32'h8000_0000, 32'h0001_0000, 1'b1));
		pending_queries.push_back(mk(32'h0002_0000, 32'h7FFF_FFFF, 32'h0001_8000, 1'b1));
		pending_queries.push_back(mk(32'h0002_0000, 32'h7FFF_FFFF, 32'h0001_8001, 1'b0));
		pending_queries.push_back(mk(32'h0002_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0));
		pending_queries.push_back(mk(32'h0002_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		pending_queries.push_back(mk(32'h0002_0000, 32'h0000_0000, 32'h0001_8000, 1'b1));
		pending_queries.push_back(mk(32'h0003_0000, 32'hFFFF_FFFF, 32'h0002_5555, 1'b1));
		pending_queries.push_back(mk(32'h0001_8000, 32'h0000_1000, 32'h0001_0000, 1'b1));
		pending_queries.push_back(mk(32'h0000_4000, 32'h0000_2000, 32'h0000_8000, 1'b1));
		pending_queries.push_back(mk(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1));
		drain();
		write_tol(16'hFFFF);
		// Times within the window overwrite instead of appending.
		pending_queries.push_back(mk(32'hFFFF_0000, 32'h0000_0100, 32'hFFFF_FFFF, 1'b1));
		pending_queries.push_back(mk(32'hFFFE_0000, 32'h0000_0200, 32'hFFFF_8000, 1'b1));
		pending_queries.push_back(mk(32'hFFFE_8000, 32'h0000_0300, 32'hFFFE_0000, 1'b0));
		drain();

		// Fill the store completely, then show a dropped append and deep searches.
		write_tol(16'd0);
		pending_queries.push_back(mk(32'd0, 32'd0, 32'd0, 1'b1));
		for (i = 1; i < HIST_DEPTH; i++)
			pending_queries.push_back(mk(i * 32'h100, $urandom, i * 32'h100, 1'b1));
		pending_queries.push_back(mk(32'h0010_0000, 32'h0000_5000, 32'h0000_0180, 1'b1));
		pending_queries.push_back(mk(32'h0010_0000, 32'h0000_5000, 32'h0000_0080, 1'b0));
		pending_queries.push_back(mk(32'h0010_0000, 32'h0000_5000, 32'h0008_0000, 1'b0));
		pending_queries.push_back(mk(32'h0000_0080, 32'h0000_6000, 32'h0000_0040, 1'b1));
		drain();
		gen_t = 32'h0000_0080;
		base_t = 32'h0000_0080;

		phase_tol[0] = 16'd0;
		phase_tol[1] = 16'hFFFF;
		phase_tol[2] = 16'($urandom_range(1, 255));
		phase_tol[3] = 16'($urandom);
		phase_tol[4] = 16'd0;
		foreach (phase_tol[p]) begin
			write_tol(phase_tol[p]);
			while (pending_queries.size() < RAND_PHASE) queue_call();
			drain();
		end

		if (awaited_results.size() != 0) begin
			$error("%0d predicted results never arrived", awaited_results.size());
			errors++;
		end
		$display("Ran %0d query beats, %0d results, %0d dropped appends.", n_sent, n_results,
			n_full);
		$display("Tolerance written %0d times, 0 and 0xFFFF among the values.", n_phases);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/tdli_pkg.sv
design/tdli_divider.sv
design/tdli_datapath.sv
design/tdli_ctrl.sv
design/timestamped_delay_line_interpolator.sv
design/tdli_checker.sv
tb/tb.sv
